>>> src/psdl_pkg.sv
// ----------------------------------------------------------------------------
// psdl_pkg
// Shared types and codes of the priority-sorted draw list.
// ----------------------------------------------------------------------------
package psdl_pkg;

    localparam int LIST_SLOTS_DEF = 512;
    localparam int ID_W           = 8;
    localparam int PRIO_W         = 15;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_NEXT   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_ENTRY = 2'd2,
        ST_END   = 2'd3
    } t_status;

    // read address source of both stores
    typedef enum logic [1:0] {
        RD_NXT    = 2'd0,
        RD_LINK   = 2'd1,
        RD_CURSOR = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   group;
        logic [ID_W-1:0]   sprite;
    } t_entry;

    typedef struct packed {
        logic    accept;
        logic    clear;
        t_rd_sel rd_sel;
        logic    walk_adv;
        logic    write_new;
        logic    link_prev;
        logic    load_nxt;
        logic    set_cursor;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic nxt_zero;
        logic rd_lower;
        logic rd_link_zero;
        logic cursor_zero;
        logic full;
    } t_dp_stat;

endpackage

>>> src/priority_sorted_draw_list.sv
// ----------------------------------------------------------------------------
// priority_sorted_draw_list
// Draw entries kept as a linked list in descending priority, equal
// priorities in arrival order, with clear, sorted insert and cursor fetch.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | beat fields
//  ----------+---------------------+---------------------------------------
//  command   | start, busy         | i_operation i_group_id i_sprite_id i_prio
//  result    | o_strobe            | o_status o_out_group o_out_sprite
//            |                     | o_out_prio
//
//  A command beat is taken on a clock edge with start high and busy low.
//  Clear, the unused code and a full-list insert answer straight from idle.
//  Insert walks from the head and links the new entry in front of the
//  first lower entry or at the tail, passing the entries of higher or equal
//  priority one link per cycle, bound by the single read port of the link
//  store. Fetch returns the entry after the cursor, or the head when the
//  cursor is zero, and answers end when it hits the end of the list.
//  Each result beat shows on o_strobe for one cycle with busy low; the
//  receiver cannot stall it. Reset (synchronous) empties the list and
//  rewinds the cursor; the stores need no clearing pass.
//
module priority_sorted_draw_list #(
    parameter int LIST_SLOTS = psdl_pkg::LIST_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [psdl_pkg::ID_W-1:0]     i_group_id,
    input  logic [psdl_pkg::ID_W-1:0]     i_sprite_id,
    input  logic [psdl_pkg::PRIO_W-1:0]   i_prio,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [psdl_pkg::ID_W-1:0]     o_out_group,
    output logic [psdl_pkg::ID_W-1:0]     o_out_sprite,
    output logic [psdl_pkg::PRIO_W-1:0]   o_out_prio
);

    psdl_pkg::t_dp_cmd  dp_cmd;
    psdl_pkg::t_dp_stat dp_stat;

    // sequencer: walks the list and steers the datapath
    psdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .busy        (busy),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // stores, pointers and the registered result beat
    psdl_datapath #(
        .LIST_SLOTS (LIST_SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_group_id   (i_group_id),
        .i_sprite_id  (i_sprite_id),
        .i_prio       (i_prio),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_out_group  (o_out_group),
        .o_out_sprite (o_out_sprite),
        .o_out_prio   (o_out_prio)
    );

`ifndef SYNTH
    // every result beat closes its command: the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    // a clear answers done on the next cycle
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == psdl_pkg::OP_CLEAR))
        |=> (o_strobe && (o_status == psdl_pkg::ST_DONE)))
        else $error("clear did not answer done");

    // entry fields are zero unless an entry is returned
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != psdl_pkg::ST_ENTRY))
        |-> ((o_out_group == '0) && (o_out_sprite == '0) && (o_out_prio == '0)))
        else $error("entry fields not cleared");

    // a command taken while idle raises busy or answers at once
    a_cmd_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("command dropped");
`endif

endmodule

>>> src/psdl_datapath.sv
// ----------------------------------------------------------------------------
// psdl_datapath
// Link and entry stores, walk pointers, list head, fill count, read cursor
// and the registered result.
// ----------------------------------------------------------------------------
module psdl_datapath #(
    parameter int LIST_SLOTS = psdl_pkg::LIST_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psdl_pkg::t_dp_cmd             i_cmd,
    output psdl_pkg::t_dp_stat            o_stat,
    input  logic [psdl_pkg::ID_W-1:0]     i_group_id,
    input  logic [psdl_pkg::ID_W-1:0]     i_sprite_id,
    input  logic [psdl_pkg::PRIO_W-1:0]   i_prio,
    output logic                          o_strobe,
    output logic [1:0]                    o_status,
    output logic [psdl_pkg::ID_W-1:0]     o_out_group,
    output logic [psdl_pkg::ID_W-1:0]     o_out_sprite,
    output logic [psdl_pkg::PRIO_W-1:0]   o_out_prio
);

    localparam int SLOT_W = $clog2(LIST_SLOTS);
    localparam int CNT_W  = $clog2(LIST_SLOTS + 1);

    logic [SLOT_W-1:0]     mem_link [LIST_SLOTS];
    psdl_pkg::t_entry      mem_ent  [LIST_SLOTS];

    logic [SLOT_W-1:0]     r_head;
    logic [CNT_W-1:0]      r_used;
    logic [SLOT_W-1:0]     r_cursor;
    logic [SLOT_W-1:0]     r_prev;
    logic [SLOT_W-1:0]     r_nxt;
    psdl_pkg::t_entry      r_new;
    logic [SLOT_W-1:0]     r_rd_link;
    psdl_pkg::t_entry      r_rd_ent;
    logic                  r_strobe;
    psdl_pkg::t_status     r_status;
    psdl_pkg::t_entry      r_out;

    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     fresh;

    assign fresh = r_used[SLOT_W-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            psdl_pkg::RD_LINK:   rd_addr = r_rd_link;
            psdl_pkg::RD_CURSOR: rd_addr = r_cursor;
            default:             rd_addr = r_nxt;
        endcase
    end

    // stores: one read address, one write address per cycle
    always_ff @(posedge i_clk) begin
        r_rd_link <= mem_link[rd_addr];
        r_rd_ent  <= mem_ent[rd_addr];
        if (i_cmd.write_new) begin
            mem_link[fresh] <= r_nxt;
            mem_ent[fresh]  <= r_new;
        end else if (i_cmd.link_prev && (r_prev != '0)) begin
            mem_link[r_prev] <= fresh;
        end
    end

    // walk pointers and pending entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prev       <= '0;
            r_nxt        <= r_head;
            r_new.prio   <= i_prio;
            r_new.group  <= i_group_id;
            r_new.sprite <= i_sprite_id;
        end else if (i_cmd.walk_adv) begin
            r_prev <= r_nxt;
            r_nxt  <= r_rd_link;
        end else if (i_cmd.load_nxt) begin
            r_nxt <= r_rd_link;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_out    <= (i_cmd.status == psdl_pkg::ST_ENTRY) ? r_rd_ent : '0;
        end
    end

    // list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_used   <= CNT_W'(1);
            r_cursor <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_head   <= '0;
                r_used   <= CNT_W'(1);
                r_cursor <= '0;
            end else begin
                if (i_cmd.link_prev) begin
                    if (r_prev == '0) begin
                        r_head <= fresh;
                    end
                    r_used <= r_used + CNT_W'(1);
                end
                if (i_cmd.set_cursor) begin
                    r_cursor <= r_nxt;
                end
            end
        end
    end

    assign o_stat.nxt_zero     = (r_nxt == '0);
    assign o_stat.rd_lower     = (r_rd_ent.prio < r_new.prio);
    assign o_stat.rd_link_zero = (r_rd_link == '0);
    assign o_stat.cursor_zero  = (r_cursor == '0);
    assign o_stat.full         = (r_used == CNT_W'(LIST_SLOTS));

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_out_group  = r_out.group;
    assign o_out_sprite = r_out.sprite;
    assign o_out_prio   = r_out.prio;

endmodule

>>> src/psdl_ctrl.sv
// ----------------------------------------------------------------------------
// psdl_ctrl
// Sequencer of clear, insert walk and fetch for the draw list.
// ----------------------------------------------------------------------------
module psdl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_operation,
    output logic                busy,
    output psdl_pkg::t_dp_cmd   o_cmd,
    input  psdl_pkg::t_dp_stat  i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_ISSUE,
        S_INS_WALK,
        S_INS_LINK,
        S_INS_HEAD,
        S_NXT_LINK,
        S_NXT_WAIT,
        S_NXT_ISSUE
    } t_state;

    typedef enum logic [0:0] {
        X_NONE,
        X_NXT_OUT
    } t_xstate;

    t_state  r_state, n_state;
    t_xstate r_out_pend, n_out_pend;

    always_comb begin
        n_state    = r_state;
        n_out_pend = X_NONE;
        o_cmd      = '0;
        o_cmd.rd_sel = psdl_pkg::RD_NXT;
        o_cmd.status = psdl_pkg::ST_DONE;
        if (r_out_pend == X_NXT_OUT) begin
            // entry data is back: hand it out and park the cursor on it
            o_cmd.set_cursor = 1'b1;
            o_cmd.emit       = 1'b1;
            o_cmd.status     = psdl_pkg::ST_ENTRY;
            n_state          = S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        o_cmd.accept = 1'b1;
                        unique case (psdl_pkg::t_op'(i_operation))
                            psdl_pkg::OP_CLEAR: begin
                                o_cmd.clear = 1'b1;
                                o_cmd.emit  = 1'b1;
                            end
                            psdl_pkg::OP_INSERT: begin
                                if (i_stat.full) begin
                                    o_cmd.emit   = 1'b1;
                                    o_cmd.status = psdl_pkg::ST_FULL;
                                end else begin
                                    n_state = S_INS_ISSUE;
                                end
                            end
                            psdl_pkg::OP_NEXT: begin
                                n_state = i_stat.cursor_zero ? S_NXT_ISSUE : S_NXT_LINK;
                            end
                            default: begin
                                o_cmd.emit = 1'b1;
                            end
                        endcase
                    end
                end
                S_INS_ISSUE: begin
                    n_state = i_stat.nxt_zero ? S_INS_LINK : S_INS_WALK;
                end
                S_INS_WALK: begin
                    if (i_stat.rd_lower) begin
                        n_state = S_INS_LINK;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                        o_cmd.rd_sel   = psdl_pkg::RD_LINK;
                        if (i_stat.rd_link_zero) begin
                            n_state = S_INS_LINK;
                        end
                    end
                end
                S_INS_LINK: begin
                    o_cmd.write_new = 1'b1;
                    n_state         = S_INS_HEAD;
                end
                S_INS_HEAD: begin
                    o_cmd.link_prev = 1'b1;
                    o_cmd.emit      = 1'b1;
                    n_state         = S_IDLE;
                end
                S_NXT_LINK: begin
                    o_cmd.rd_sel = psdl_pkg::RD_CURSOR;
                    n_state      = S_NXT_WAIT;
                end
                S_NXT_WAIT: begin
                    o_cmd.load_nxt = 1'b1;
                    n_state        = S_NXT_ISSUE;
                end
                S_NXT_ISSUE: begin
                    if (i_stat.nxt_zero) begin
                        o_cmd.set_cursor = 1'b1;
                        o_cmd.emit       = 1'b1;
                        o_cmd.status     = psdl_pkg::ST_END;
                        n_state          = S_IDLE;
                    end else begin
                        n_out_pend = X_NXT_OUT;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_pend <= X_NONE;
        end else begin
            r_state    <= n_state;
            r_out_pend <= n_out_pend;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
